FILE: rtl/core/cursor_overlay_compositor_unit_macros.svh
// ---------------------------------------------------------------------------
// Cursor overlay compositor assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef CURSOR_OVERLAY_COMPOSITOR_UNIT_MACROS_SVH
`define CURSOR_OVERLAY_COMPOSITOR_UNIT_MACROS_SVH

// same-cycle implication
`define COC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define COC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/coc_pkg.sv
// ---------------------------------------------------------------------------
// Cursor overlay compositor package
// Shared widths, codes, stage structs and the divide-by-255 helper
// ---------------------------------------------------------------------------
package coc_pkg;

  // default sizes
  localparam int unsigned ShapeWordsDefault = 4096;
  localparam int unsigned CoordBitsDefault  = 13;

  // field widths
  localparam int unsigned AddrW     = 12;
  localparam int unsigned WordW     = 32;
  localparam int unsigned PixW      = 32;
  localparam int unsigned DimW      = 14;
  localparam int unsigned ShapeWW   = 9;
  localparam int unsigned ShapeHW   = 10;
  localparam int unsigned PitchW    = 11;
  localparam int unsigned PrW       = 20;
  localparam int unsigned ByteAddrW = 23;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCursorX      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCursorY      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgShapeWidth   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgShapeHeight  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgShapePitch   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgShapeMode    = 3'd7;

  // request kinds
  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdCompose = 1'b1;

  // pixel constants
  localparam logic [PixW-1:0] AlphaOpaque = 32'hFF00_0000;
  localparam logic [PixW-1:0] ColorMask   = 32'h00FF_FFFF;
  localparam logic [PixW-1:0] AllOnes     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ALPHA = 2'd1,
    MODE_MASK  = 2'd2,
    MODE_MONO  = 2'd3
  } mode_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [DimW-1:0]    screen_w;
    logic [DimW-1:0]    screen_h;
    logic [DimW-1:0]    org_x;
    logic [DimW-1:0]    org_y;
    logic [ShapeWW-1:0] shape_w;
    logic [ShapeHW-1:0] rows;
    logic [PitchW-1:0]  pitch;
    logic [PrW-1:0]     pitch_rows;
    mode_e              mode;
  } cfg_t;

  // after the hit test
  typedef struct packed {
    logic              cmd;
    logic [AddrW-1:0]  addr;
    logic [WordW-1:0]  word;
    logic [PixW-1:0]   pixel;
    logic              cov;
    logic [ShapeWW-1:0] dx;
    logic [ShapeHW-1:0] dy;
  } hit_t;

  // sideband next to the shape read data
  typedef struct packed {
    logic            cmd;
    logic [PixW-1:0] pixel;
    logic            cov;
    logic [1:0]      off0;
    logic [1:0]      off1;
    logic [2:0]      bit_idx;
  } fetch_t;

  // blend products and the non-blend result
  typedef struct packed {
    logic [PixW-1:0]  alt;
    logic             cov;
    logic             blend;
    logic [2:0][15:0] pf;
    logic [2:0][15:0] pb;
  } shade_t;

  // exact x / 255 for x below 255 * 256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

FILE: rtl/core/cursor_overlay_compositor_unit.sv
// ---------------------------------------------------------------------------
// Cursor overlay compositor
// Hardware cursor applied to a background pixel stream
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser is the kind: 0 writes shape_word into the
//   shape store at shape_addr, 1 composes pixel at (pos_x, pos_y).
//   m_axis returns one result per request: the composited pixel in tdata and
//   the coverage flag in tuser; write requests return zero for both.
//   The cfg channel writes the screen, cursor and shape registers; it is
//   always ready and must only be used while no request is in flight.
// Timing:
//   five-register pipeline (input, hit test, shape read, blend products,
//   result), each request passing through them in that order.
//   One request per cycle is sustained while m_axis accepts results; the
//   shape memory read and the blend multipliers each sit in their own stage.
//   Store writes land in time for the very next request.
// Reset and stalls:
//   reset empties the pipeline and loads the register defaults; the shape
//   store is not cleared. A stalled m_axis holds its result, and the
//   upstream stages keep filling bubbles until every stage holds a request,
//   only then does s_axis_tready drop.
// ---------------------------------------------------------------------------
`include "cursor_overlay_compositor_unit_macros.svh"

module cursor_overlay_compositor_unit #(
  parameter int unsigned ShapeWords = coc_pkg::ShapeWordsDefault,
  parameter int unsigned CoordBits  = coc_pkg::CoordBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request: shape_addr, shape_word, pixel, pos_x, pos_y (from bit 0 up)
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [((76+2*CoordBits+7)/8)*8-1:0] s_axis_tdata,
  // request: cmd
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result: pixel_out
  output logic [coc_pkg::PixW-1:0]      m_axis_tdata,
  // result: covered
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [coc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [coc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned OffWord  = coc_pkg::AddrW;
  localparam int unsigned OffPixel = OffWord + coc_pkg::WordW;
  localparam int unsigned OffPosX  = OffPixel + coc_pkg::PixW;
  localparam int unsigned OffPosY  = OffPosX + CoordBits;

  coc_pkg::cfg_t             cfg;
  coc_pkg::hit_t             hit;
  coc_pkg::fetch_t           fetch;
  logic [coc_pkg::WordW-1:0] rd0, rd1;

  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic en1, en2, en3, en4, en_out;

  // stage advance: a stage moves when it is empty or its successor moves
  always_comb begin
    en_out = !out_valid_q || m_axis_tready;
    en4    = !v4_q || en_out;
    en3    = !v3_q || en4;
    en2    = !v2_q || en3;
    en1    = !v1_q || en2;
  end

  assign s_axis_tready = en1;
  assign m_axis_tvalid = out_valid_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= s_axis_tvalid;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en_out) out_valid_q <= v4_q;
    end
  end

  coc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  coc_hit #(
    .CoordBits (CoordBits)
  ) u_hit (
    .clk_i   (clk_i),
    .en1_i   (en1),
    .en2_i   (en2),
    .cmd_i   (s_axis_tuser),
    .addr_i  (s_axis_tdata[OffWord-1:0]),
    .word_i  (s_axis_tdata[OffPixel-1:OffWord]),
    .pixel_i (s_axis_tdata[OffPosX-1:OffPixel]),
    .pos_x_i (s_axis_tdata[OffPosY-1:OffPosX]),
    .pos_y_i (s_axis_tdata[OffPosY+CoordBits-1:OffPosY]),
    .cfg_i   (cfg),
    .hit_o   (hit)
  );

  coc_store #(
    .ShapeWords (ShapeWords)
  ) u_store (
    .clk_i   (clk_i),
    .en3_i   (en3),
    .v2_i    (v2_q),
    .hit_i   (hit),
    .cfg_i   (cfg),
    .fetch_o (fetch),
    .rd0_o   (rd0),
    .rd1_o   (rd1)
  );

  coc_shade u_shade (
    .clk_i     (clk_i),
    .en4_i     (en4),
    .en_out_i  (en_out),
    .fetch_i   (fetch),
    .rd0_i     (rd0),
    .rd1_i     (rd1),
    .cfg_i     (cfg),
    .pixel_o   (m_axis_tdata),
    .covered_o (m_axis_tuser)
  );

  // an empty result register always lets the input side in
  `COC_ASSERT_NOW(a_ready_when_out_empty, !out_valid_q, s_axis_tready, "input blocked with empty output")
  // input only blocks once every stage is occupied and the sink stalls
  `COC_ASSERT_NOW(a_ready_drop_full, !s_axis_tready, v1_q && v2_q && v3_q && v4_q && out_valid_q && !m_axis_tready, "input blocked with a bubble in the pipe")
  // the hit stage takes over the input stage valid when it advances
  `COC_ASSERT_NEXT(a_v2_follows_v1, en2, v2_q == $past(v1_q), "hit stage valid lost or duplicated")

endmodule

FILE: rtl/core/coc_cfg.sv
// ---------------------------------------------------------------------------
// Cursor overlay configuration registers
// Register file with the clamped cursor origin and plane offset kept ready
// ---------------------------------------------------------------------------
module coc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [coc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [coc_pkg::CfgDataW-1:0]  cfg_data_i,
  output coc_pkg::cfg_t                 cfg_o
);

  logic [coc_pkg::DimW-1:0]    sw_q, sh_q, cx_q, cy_q;
  logic [coc_pkg::ShapeWW-1:0] shw_q;
  logic [coc_pkg::ShapeHW-1:0] shh_q;
  logic [coc_pkg::PitchW-1:0]  pitch_q;
  coc_pkg::mode_e              mode_q;

  logic [coc_pkg::DimW-1:0]    ox_d, ox_q, oy_d, oy_q;
  logic [coc_pkg::ShapeHW-1:0] rows_d, rows_q;
  logic [coc_pkg::PrW-1:0]     pr_d, pr_q;

  // negative goes to zero, beyond the screen edge goes to the edge
  function automatic logic [coc_pkg::DimW-1:0] clamp_org(
    input logic [coc_pkg::DimW-1:0] pos,
    input logic [coc_pkg::DimW-1:0] lim
  );
    if (pos[coc_pkg::DimW-1]) begin
      return '0;
    end else if (pos > lim) begin
      return lim;
    end
    return pos;
  endfunction

  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= 14'd1920;
      sh_q    <= 14'd1080;
      cx_q    <= '0;
      cy_q    <= '0;
      shw_q   <= '0;
      shh_q   <= '0;
      pitch_q <= '0;
      mode_q  <= coc_pkg::MODE_NONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        coc_pkg::CfgScreenWidth:  sw_q    <= cfg_data_i[coc_pkg::DimW-1:0];
        coc_pkg::CfgScreenHeight: sh_q    <= cfg_data_i[coc_pkg::DimW-1:0];
        coc_pkg::CfgCursorX:      cx_q    <= cfg_data_i[coc_pkg::DimW-1:0];
        coc_pkg::CfgCursorY:      cy_q    <= cfg_data_i[coc_pkg::DimW-1:0];
        coc_pkg::CfgShapeWidth:   shw_q   <= cfg_data_i[coc_pkg::ShapeWW-1:0];
        coc_pkg::CfgShapeHeight:  shh_q   <= cfg_data_i[coc_pkg::ShapeHW-1:0];
        coc_pkg::CfgShapePitch:   pitch_q <= cfg_data_i[coc_pkg::PitchW-1:0];
        coc_pkg::CfgShapeMode:    mode_q  <= coc_pkg::mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // derived values, registered from the raw registers
  always_comb begin
    ox_d   = clamp_org(cx_q, sw_q);
    oy_d   = clamp_org(cy_q, sh_q);
    rows_d = (mode_q == coc_pkg::MODE_MONO) ? {1'b0, shh_q[coc_pkg::ShapeHW-1:1]} : shh_q;
    pr_d   = {9'd0, pitch_q} * {11'd0, shh_q[coc_pkg::ShapeHW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q   <= '0;
      oy_q   <= '0;
      rows_q <= '0;
      pr_q   <= '0;
    end else begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      rows_q <= rows_d;
      pr_q   <= pr_d;
    end
  end

  always_comb begin
    cfg_o.screen_w   = sw_q;
    cfg_o.screen_h   = sh_q;
    cfg_o.org_x      = ox_q;
    cfg_o.org_y      = oy_q;
    cfg_o.shape_w    = shw_q;
    cfg_o.rows       = rows_q;
    cfg_o.pitch      = pitch_q;
    cfg_o.pitch_rows = pr_q;
    cfg_o.mode       = mode_q;
  end

endmodule

FILE: rtl/core/coc_hit.sv
// ---------------------------------------------------------------------------
// Cursor overlay hit test
// Input register and the screen and shape bounds check for each request
// ---------------------------------------------------------------------------
module coc_hit #(
  parameter int unsigned CoordBits = coc_pkg::CoordBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       en1_i,
  input  logic                       en2_i,
  input  logic                       cmd_i,
  input  logic [coc_pkg::AddrW-1:0]  addr_i,
  input  logic [coc_pkg::WordW-1:0]  word_i,
  input  logic [coc_pkg::PixW-1:0]   pixel_i,
  input  logic [CoordBits-1:0]       pos_x_i,
  input  logic [CoordBits-1:0]       pos_y_i,
  input  coc_pkg::cfg_t              cfg_i,
  output coc_pkg::hit_t              hit_o
);

  localparam int unsigned XW =
    ((CoordBits > coc_pkg::DimW) ? CoordBits : coc_pkg::DimW) + 1;

  logic                      cmd_q;
  logic [coc_pkg::AddrW-1:0] addr_q;
  logic [coc_pkg::WordW-1:0] word_q;
  logic [coc_pkg::PixW-1:0]  pixel_q;
  logic [CoordBits-1:0]      px_q, py_q;

  logic [XW-1:0] px_x, py_x, sw_x, sh_x, ox_x, oy_x, dx_x, dy_x, shw_x, rows_x;
  logic          in_x, in_y;
  coc_pkg::hit_t hit_d, hit_q;

  // input register
  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      word_q  <= word_i;
      pixel_q <= pixel_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
    end
  end

  // bounds against screen, clamped origin and shape size
  always_comb begin
    px_x   = {{(XW-CoordBits){1'b0}}, px_q};
    py_x   = {{(XW-CoordBits){1'b0}}, py_q};
    sw_x   = {{(XW-coc_pkg::DimW){1'b0}}, cfg_i.screen_w};
    sh_x   = {{(XW-coc_pkg::DimW){1'b0}}, cfg_i.screen_h};
    ox_x   = {{(XW-coc_pkg::DimW){1'b0}}, cfg_i.org_x};
    oy_x   = {{(XW-coc_pkg::DimW){1'b0}}, cfg_i.org_y};
    shw_x  = {{(XW-coc_pkg::ShapeWW){1'b0}}, cfg_i.shape_w};
    rows_x = {{(XW-coc_pkg::ShapeHW){1'b0}}, cfg_i.rows};
    dx_x   = px_x - ox_x;
    dy_x   = py_x - oy_x;
    in_x   = (px_x < sw_x) && (px_x >= ox_x) && (dx_x < shw_x);
    in_y   = (py_x < sh_x) && (py_x >= oy_x) && (dy_x < rows_x);

    hit_d.cmd   = cmd_q;
    hit_d.addr  = addr_q;
    hit_d.word  = word_q;
    hit_d.pixel = pixel_q;
    hit_d.cov   = (cfg_i.mode != coc_pkg::MODE_NONE) && in_x && in_y;
    hit_d.dx    = dx_x[coc_pkg::ShapeWW-1:0];
    hit_d.dy    = dy_x[coc_pkg::ShapeHW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

FILE: rtl/core/coc_store.sv
// ---------------------------------------------------------------------------
// Cursor overlay shape store
// Shape address generation and the shape memory, one write and two reads
// ---------------------------------------------------------------------------
module coc_store #(
  parameter int unsigned ShapeWords = coc_pkg::ShapeWordsDefault
) (
  input  logic                       clk_i,
  input  logic                       en3_i,
  input  logic                       v2_i,
  input  coc_pkg::hit_t              hit_i,
  input  coc_pkg::cfg_t              cfg_i,
  output coc_pkg::fetch_t            fetch_o,
  output logic [coc_pkg::WordW-1:0]  rd0_o,
  output logic [coc_pkg::WordW-1:0]  rd1_o
);

  // word address width; the store size must be a power of two, not checked here
  localparam int unsigned AW = $clog2(ShapeWords);

  logic [coc_pkg::ByteAddrW-1:0] prod, a_col, b0, b1;
  logic                          mono, we;
  logic [AW-1:0]                 ra0, ra1, waddr;
  logic [31:0]                   wa_ext;
  coc_pkg::fetch_t               fetch_d, fetch_q;

  logic [coc_pkg::WordW-1:0] mem_q [ShapeWords];
  logic [coc_pkg::WordW-1:0] rd0_q, rd1_q;

  // byte offsets: color pixel, monochrome and-plane and xor-plane
  always_comb begin
    prod  = {13'd0, hit_i.dy} * {12'd0, cfg_i.pitch};
    a_col = prod + {12'd0, hit_i.dx, 2'b00};
    b0    = prod + {17'd0, hit_i.dx[coc_pkg::ShapeWW-1:3]};
    b1    = b0 + {3'd0, cfg_i.pitch_rows};
    mono  = (cfg_i.mode == coc_pkg::MODE_MONO);
    ra0   = mono ? b0[AW+1:2] : a_col[AW+1:2];
    ra1   = mono ? b1[AW+1:2] : a_col[AW+1:2] + {{(AW-1){1'b0}}, 1'b1};
    wa_ext = {20'd0, hit_i.addr};
    waddr  = wa_ext[AW-1:0];
    we     = en3_i && v2_i && (hit_i.cmd == coc_pkg::CmdWrite);

    fetch_d.cmd     = hit_i.cmd;
    fetch_d.pixel   = hit_i.pixel;
    fetch_d.cov     = hit_i.cov;
    fetch_d.off0    = mono ? b0[1:0] : a_col[1:0];
    fetch_d.off1    = b1[1:0];
    fetch_d.bit_idx = hit_i.dx[2:0];
  end

  // shape memory, reads registered
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= hit_i.word;
    end
    if (en3_i) begin
      rd0_q <= mem_q[ra0];
      rd1_q <= mem_q[ra1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      fetch_q <= fetch_d;
    end
  end

  assign fetch_o = fetch_q;
  assign rd0_o   = rd0_q;
  assign rd1_o   = rd1_q;

endmodule

FILE: rtl/core/coc_shade.sv
// ---------------------------------------------------------------------------
// Cursor overlay shading
// Mode selection, alpha blend products and the result register
// ---------------------------------------------------------------------------
module coc_shade (
  input  logic                       clk_i,
  input  logic                       en4_i,
  input  logic                       en_out_i,
  input  coc_pkg::fetch_t            fetch_i,
  input  logic [coc_pkg::WordW-1:0]  rd0_i,
  input  logic [coc_pkg::WordW-1:0]  rd1_i,
  input  coc_pkg::cfg_t              cfg_i,
  output logic [coc_pkg::PixW-1:0]   pixel_o,
  output logic                       covered_o
);

  logic [63:0]               pair;
  logic [coc_pkg::PixW-1:0]  fg, bg, a32, x32, mono_res, mask_res;
  logic [7:0]                byte_a, byte_x, fa;
  logic                      am, xm;
  coc_pkg::shade_t           shade_d, shade_q;
  logic [2:0][7:0]           chan;
  logic [coc_pkg::PixW-1:0]  blended;
  logic [coc_pkg::PixW-1:0]  pixel_q;
  logic                      cov_q;

  assign pair = {rd1_i, rd0_i};
  assign bg   = fetch_i.pixel;

  // unaligned color word and the two monochrome bytes
  always_comb begin
    case (fetch_i.off0)
      2'd0:    fg = pair[31:0];
      2'd1:    fg = pair[39:8];
      2'd2:    fg = pair[47:16];
      default: fg = pair[55:24];
    endcase
    case (fetch_i.off0)
      2'd0:    byte_a = rd0_i[7:0];
      2'd1:    byte_a = rd0_i[15:8];
      2'd2:    byte_a = rd0_i[23:16];
      default: byte_a = rd0_i[31:24];
    endcase
    case (fetch_i.off1)
      2'd0:    byte_x = rd1_i[7:0];
      2'd1:    byte_x = rd1_i[15:8];
      2'd2:    byte_x = rd1_i[23:16];
      default: byte_x = rd1_i[31:24];
    endcase
  end

  // monochrome and masked results, blend products
  always_comb begin
    am       = byte_a[3'd7 - fetch_i.bit_idx];
    xm       = byte_x[3'd7 - fetch_i.bit_idx];
    a32      = am ? coc_pkg::AllOnes : coc_pkg::AlphaOpaque;
    x32      = xm ? coc_pkg::ColorMask : '0;
    mono_res = (bg & a32) ^ x32;
    mask_res = (fg[31:24] != 8'd0) ? ((bg ^ fg) | coc_pkg::AlphaOpaque) : fg;
    fa       = fg[31:24];

    if (fetch_i.cmd == coc_pkg::CmdWrite) begin
      shade_d.alt = '0;
    end else if (!fetch_i.cov) begin
      shade_d.alt = bg;
    end else begin
      case (cfg_i.mode)
        coc_pkg::MODE_MONO: shade_d.alt = mono_res;
        coc_pkg::MODE_MASK: shade_d.alt = mask_res;
        default:            shade_d.alt = bg;
      endcase
    end
    shade_d.cov   = fetch_i.cov && (fetch_i.cmd == coc_pkg::CmdCompose);
    shade_d.blend = shade_d.cov && (cfg_i.mode == coc_pkg::MODE_ALPHA);
    for (int i = 0; i < 3; i++) begin
      shade_d.pf[i] = {8'd0, fg[8*i +: 8]} * {8'd0, fa};
      shade_d.pb[i] = {8'd0, bg[8*i +: 8]} * {8'd0, ~fa};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      shade_q <= shade_d;
    end
  end

  // scale back by 255 and assemble, alpha forced opaque
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan[i] = coc_pkg::div255(shade_q.pf[i]) + coc_pkg::div255(shade_q.pb[i]);
    end
    blended = {coc_pkg::AlphaOpaque[31:24], chan[2], chan[1], chan[0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_out_i) begin
      pixel_q <= shade_q.blend ? blended : shade_q.alt;
      cov_q   <= shade_q.cov;
    end
  end

  assign pixel_o   = pixel_q;
  assign covered_o = cov_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cursor overlay compositor testbench
// Streams shape writes and background pixels through the compositor under a
// series of screen, cursor and shape settings. Each accepted request is
// predicted in order and every result is compared field by field. Shape
// words are loaded before any compose request can read them, and both
// stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
  import coc_pkg::*;

  localparam int unsigned COORD_W     = CoordBitsDefault;
  localparam int unsigned TDATA_W     = ((76 + 2 * COORD_W + 7) / 8) * 8;
  localparam int unsigned STORE_BYTES = ShapeWordsDefault * 4;
  localparam int unsigned QUIET_LIMIT = 1000;

  typedef struct packed {
    logic               cmd;
    logic [AddrW-1:0]   addr;
    logic [WordW-1:0]   word;
    logic [PixW-1:0]    pixel;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } request_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            covered;
  } overlay_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // shape_addr, shape_word, pixel, pos_x, pos_y, zero fill (from bit 0 up)
  logic [TDATA_W-1:0]  s_axis_tdata  = '0;
  // cmd
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // pixel_out
  logic [PixW-1:0]     m_axis_tdata;
  // covered
  logic                m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // register copy, reset values
  logic [DimW-1:0]        scr_w     = 14'd1920;
  logic [DimW-1:0]        scr_h     = 14'd1080;
  logic signed [DimW-1:0] cur_x     = '0;
  logic signed [DimW-1:0] cur_y     = '0;
  logic [ShapeWW-1:0]     shp_w     = '0;
  logic [ShapeHW-1:0]     shp_h     = '0;
  logic [PitchW-1:0]      shp_pitch = '0;
  mode_e                  shp_mode  = MODE_NONE;

  // shape store as the block holds it, and which words the requests load
  logic [WordW-1:0] shape_mem   [ShapeWordsDefault];
  bit               word_loaded [ShapeWordsDefault];

  request_t    req_q[$];
  overlay_t    overlay_q[$];
  request_t    drv_req;
  overlay_t    want;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned calm_left[2] = '{0, 0};
  int unsigned queued_cnt   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  cursor_overlay_compositor_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int unsigned idle_len(input int side);
    int unsigned r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // cursor origin clamped to the screen
  function automatic int unsigned origin(input logic signed [DimW-1:0] pos,
                                         input logic [DimW-1:0] lim);
    if (pos < 0) return 0;
    if (int'(pos) > int'(lim)) return lim;
    return int'(pos);
  endfunction

  // hit test; on a hit gives the store byte addresses the shape read uses
  // (monochrome: and plane, xor plane; color: the four bytes of the word)
  function automatic bit find_taps(input logic [COORD_W-1:0] px, py,
                                   output int unsigned dx,
                                   output int unsigned tap[4]);
    int unsigned ox, oy, dy, rows, base;
    dx = 0;
    foreach (tap[k]) tap[k] = 0;
    ox = origin(cur_x, scr_w);
    oy = origin(cur_y, scr_h);
    rows = (shp_mode == MODE_MONO) ? shp_h / 2 : shp_h;
    if (shp_mode == MODE_NONE || px >= scr_w || py >= scr_h || px < ox || py < oy)
      return 1'b0;
    dx = px - ox;
    dy = py - oy;
    if (dx >= shp_w || dy >= rows) return 1'b0;
    if (shp_mode == MODE_MONO) begin
      tap[0] = (dx / 8 + shp_pitch * dy) % STORE_BYTES;
      tap[1] = (dx / 8 + shp_pitch * (dy + rows)) % STORE_BYTES;
      tap[2] = tap[0];
      tap[3] = tap[1];
    end else begin
      base = dy * shp_pitch + dx * 4;
      foreach (tap[k]) tap[k] = (base + k) % STORE_BYTES;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] shape_byte(input int unsigned ba);
    return shape_mem[ba / 4][8 * (ba % 4) +: 8];
  endfunction

  // per channel fg * a / 255 + bg * (255 - a) / 255, opaque result
  function automatic logic [PixW-1:0] alpha_blend(input logic [PixW-1:0] bg, fg);
    int unsigned fa, f, b, c;
    logic [PixW-1:0] o;
    fa = fg[31:24];
    o = AlphaOpaque;
    for (int s = 0; s < 3; s++) begin
      f = fg[8 * s +: 8];
      b = bg[8 * s +: 8];
      c = f * fa / 255 + b * (255 - fa) / 255;
      o[8 * s +: 8] = c[7:0];
    end
    return o;
  endfunction

  // expected result of one accepted request; writes update the store copy
  function automatic overlay_t predict_result(input request_t r);
    overlay_t        res;
    int unsigned     dx;
    int unsigned     tap[4];
    logic [PixW-1:0] fg;
    logic [7:0]      pick;
    res.pixel = r.pixel;
    res.covered = 1'b0;
    if (r.cmd == CmdWrite) begin
      shape_mem[r.addr] = r.word;
      res.pixel = '0;
    end else if (find_taps(r.pos_x, r.pos_y, dx, tap)) begin
      res.covered = 1'b1;
      if (shp_mode == MODE_MONO) begin
        pick = 8'h80 >> (dx % 8);
        res.pixel = (r.pixel & ((shape_byte(tap[0]) & pick) != 0 ? AllOnes : AlphaOpaque))
                    ^ ((shape_byte(tap[1]) & pick) != 0 ? ColorMask : '0);
      end else begin
        fg = {shape_byte(tap[3]), shape_byte(tap[2]), shape_byte(tap[1]), shape_byte(tap[0])};
        if (shp_mode == MODE_ALPHA) res.pixel = alpha_blend(r.pixel, fg);
        else if ((fg & AlphaOpaque) != 0) res.pixel = (r.pixel ^ fg) | AlphaOpaque;
        else res.pixel = fg;
      end
    end
    return res;
  endfunction

  // shape word with a fair share of transparent and opaque alpha
  function automatic logic [WordW-1:0] shape_fill();
    logic [WordW-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0: w[31:24] = 8'h00;
      1: w[31:24] = 8'hFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic void add_write(input logic [AddrW-1:0] addr,
                                    input logic [WordW-1:0] word);
    request_t r;
    r.cmd   = CmdWrite;
    r.addr  = addr;
    r.word  = word;
    r.pixel = $urandom;
    r.pos_x = COORD_W'($urandom);
    r.pos_y = COORD_W'($urandom);
    req_q.push_back(r);
    word_loaded[addr] = 1'b1;
    queued_cnt++;
  endfunction

  // compose request, preceded by writes for any shape word not yet loaded
  function automatic void add_compose(input logic [COORD_W-1:0] px, py,
                                      input logic [PixW-1:0] pix);
    request_t    r;
    int unsigned dx;
    int unsigned tap[4];
    if (find_taps(px, py, dx, tap))
      foreach (tap[k])
        if (!word_loaded[tap[k] / 4]) add_write(AddrW'(tap[k] / 4), shape_fill());
    r.cmd   = CmdCompose;
    r.addr  = AddrW'($urandom);
    r.word  = $urandom;
    r.pixel = pix;
    r.pos_x = px;
    r.pos_y = py;
    req_q.push_back(r);
    queued_cnt++;
  endfunction

  // some shape writes, mostly pixels around the cursor, some at the screen edge, some anywhere
  function automatic void add_random_item();
    int unsigned        ox, oy, rows, sel;
    logic [COORD_W-1:0] px, py;
    ox = origin(cur_x, scr_w);
    oy = origin(cur_y, scr_h);
    rows = (shp_mode == MODE_MONO) ? shp_h / 2 : shp_h;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      add_write(AddrW'($urandom_range(0, ShapeWordsDefault - 1)), shape_fill());
      return;
    end
    if (sel < 75) begin
      px = COORD_W'(ox + $urandom_range(0, shp_w + 2));
      py = COORD_W'(oy + $urandom_range(0, rows + 2));
    end else if (sel < 82) begin
      px = COORD_W'(scr_w - $urandom_range(0, 1));
      py = COORD_W'(scr_h - $urandom_range(0, 1));
    end else begin
      px = COORD_W'($urandom);
      py = COORD_W'($urandom);
    end
    add_compose(px, py, $urandom);
  endfunction

  function automatic void flag_mismatch(input string what,
                                        input logic [31:0] exp_val, got_val);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("[%0t] %s: expected %08h, got %08h", $time, what, exp_val, got_val);
  endfunction

  // register write, called at a rising edge; keeps the copy in step
  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgScreenWidth:  scr_w = val[DimW-1:0];
      CfgScreenHeight: scr_h = val[DimW-1:0];
      CfgCursorX:      cur_x = val[DimW-1:0];
      CfgCursorY:      cur_y = val[DimW-1:0];
      CfgShapeWidth:   shp_w = val[ShapeWW-1:0];
      CfgShapeHeight:  shp_h = val[ShapeHW-1:0];
      CfgShapePitch:   shp_pitch = val[PitchW-1:0];
      CfgShapeMode:    shp_mode = mode_e'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic load_setup(input int sw, sh, cx, cy, w, h, pitch, input mode_e mode);
    set_reg(CfgScreenWidth, CfgDataW'(sw));
    set_reg(CfgScreenHeight, CfgDataW'(sh));
    set_reg(CfgCursorX, {2'b00, 14'(cx)});
    set_reg(CfgCursorY, {2'b00, 14'(cy)});
    set_reg(CfgShapeWidth, CfgDataW'(w));
    set_reg(CfgShapeHeight, CfgDataW'(h));
    set_reg(CfgShapePitch, CfgDataW'(pitch));
    set_reg(CfgShapeMode, CfgDataW'(mode));
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every queued request has come back, then let the pipe settle
  task automatic drain();
    @(posedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || overlay_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) overlay_q.push_back(predict_result(drv_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          drv_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TDATA_W'({drv_req.pos_y, drv_req.pos_x, drv_req.pixel,
                                     drv_req.word, drv_req.addr});
          s_axis_tuser  <= drv_req.cmd;
          send_gap = idle_len(0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (overlay_q.size() == 0) begin
          flag_mismatch("result with no request pending", '0, m_axis_tdata);
        end else begin
          want = overlay_q.pop_front();
          if (m_axis_tdata !== want.pixel) flag_mismatch("pixel_out", want.pixel, m_axis_tdata);
          if (m_axis_tuser !== want.covered)
            flag_mismatch("covered", want.covered, m_axis_tuser);
        end
        recv_stall = idle_len(1);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, directed phases, then random phases
  initial begin
    int    sw, sh, cx, cy, w, h, pitch, quota, start;
    mode_e mode;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no cursor, pixels pass through; store address extremes
    add_write('0, '0);
    add_write('1, AllOnes);
    add_compose('0, '0, '0);
    add_compose('1, '1, AllOnes);
    drain();

    // alpha blend: transparent, opaque and half alpha, plus misses
    load_setup(64, 48, 2, 3, 4, 2, 16, MODE_ALPHA);
    add_write(0, 32'h0012_3456);
    add_write(1, 32'hFFA5_C3E1);
    add_write(2, 32'h80FF_7F01);
    add_compose(2, 3, 32'h00FF_FFFF);
    add_compose(3, 3, 32'h1234_5678);
    add_compose(4, 3, 32'h7F00_80FF);
    add_compose(6, 3, 32'hDEAD_BEEF);
    add_compose(1, 3, 32'hCAFE_F00D);
    add_compose(64, 3, 32'h0BAD_CAFE);
    add_compose(2, 5, 32'h5A5A_A5A5);
    drain();

    // masked color: zero alpha replaces, nonzero alpha inverts
    load_setup(64, 48, 2, 3, 4, 2, 16, MODE_MASK);
    add_write(4, 32'h00AB_CDEF);
    add_write(5, 32'h010F_0F0F);
    add_compose(2, 4, 32'h3355_77AA);
    add_compose(3, 4, 32'hF0F0_F0F0);
    drain();

    // monochrome: all four and / xor bit combinations
    load_setup(16, 16, 0, 0, 8, 2, 4, MODE_MONO);
    add_write(0, 32'h0000_00F0);
    add_write(1, 32'h0000_00CC);
    add_compose(0, 0, 32'h1234_5678);
    add_compose(2, 0, 32'h89AB_CDEF);
    add_compose(4, 0, 32'hFFFF_FFFF);
    add_compose(6, 0, 32'h0000_0000);
    drain();

    for (int p = 0; p < 11; p++) begin
      sw    = $urandom_range(16, 200);
      sh    = $urandom_range(16, 200);
      cx    = int'($urandom_range(0, sw)) - 4;
      cy    = int'($urandom_range(0, sh)) - 4;
      w     = $urandom_range(1, 24);
      h     = $urandom_range(1, 24);
      pitch = $urandom_range(0, 128);
      mode  = mode_e'($urandom_range(0, 3));
      quota = 105;
      case (p)
        // 256 by 512 shape, store offsets wrap, cursor clamped at zero
        0: begin
          sw = 8192; sh = 8192; cx = -8192; cy = -8192;
          w = 256; h = 512; pitch = 1024; mode = MODE_ALPHA;
        end
        // tiny screen, cursor clamped past its edge
        1: begin
          sw = 1; sh = 1; cx = 8191; cy = 8191; mode = MODE_MASK; quota = 40;
        end
        2: begin
          h = 2 * $urandom_range(1, 12) + 1; mode = MODE_MONO;
        end
        // unaligned color words
        3: begin
          pitch = 4 * $urandom_range(4, 20) + $urandom_range(1, 3); mode = MODE_ALPHA;
        end
        4: begin
          mode = MODE_NONE; quota = 40;
        end
        5: begin
          pitch = 0; mode = MODE_MASK;
        end
        6: begin
          w = 0; mode = MODE_MONO; quota = 40;
        end
        7: begin
          h = 0; mode = MODE_ALPHA; quota = 40;
        end
        // 256 by 512 monochrome shape, xor plane offsets wrap
        8: begin
          sw = 8192; sh = 8192; cx = $urandom_range(0, 40); cy = $urandom_range(0, 40);
          w = 256; h = 512; pitch = 1024; mode = MODE_MONO;
        end
        // cursor at the far corner of a full screen
        9: begin
          sw = 8192; sh = 8192; cx = 8191; cy = 8191; mode = MODE_MASK; quota = 40;
        end
        default: ;
      endcase
      load_setup(sw, sh, cx, cy, w, h, pitch, mode);
      start = queued_cnt;
      while (queued_cnt - start < quota) add_random_item();
      drain();
    end

    if (mismatch_cnt == 0 && overlay_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/coc_pkg.sv
rtl/core/coc_cfg.sv
rtl/core/coc_hit.sv
rtl/core/coc_store.sv
rtl/core/coc_shade.sv
rtl/core/cursor_overlay_compositor_unit.sv
tb/tb_top.sv
